// ===== src/pfr_pkg.sv =====
// pfr_pkg: shared types and constants for the packet frame receiver
// no dependencies; used by pfr_step and packet_frame_receiver_core
package pfr_pkg;

    localparam logic [7:0] HEAD_BYTE = 8'hCC;
    localparam logic [7:0] TAIL_BYTE = 8'hB9;

    // receiver phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_BODY  = 5'b00100,
        PH_TAIL  = 5'b01000,
        PH_CHECK = 5'b10000
    } t_phase;

    // result event codes
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_BYTE = 2'd1,
        EV_GOOD = 2'd2,
        EV_BAD  = 2'd3
    } t_event;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] body_length;
        logic [7:0] body_count;
        logic [7:0] checksum;
    } t_state;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] byte_value;
        logic [6:0] byte_index;
        logic [7:0] frame_length;
        logic [7:0] running_checksum;
    } t_result;

endpackage

// ===== src/pfr_step.sv =====
// pfr_step: per-byte next-state and result logic of the frame receiver
// depends on pfr_pkg
module pfr_step #(
    parameter int MAX_LEN = 128
) (
    input  pfr_pkg::t_state  i_state,
    input  logic [7:0]       i_rx_byte,
    output pfr_pkg::t_state  o_state,
    output pfr_pkg::t_result o_result
);

    localparam logic [7:0] MaxLen = 8'(MAX_LEN);

    logic [7:0] rot;
    logic [7:0] folded;
    logic [7:0] count_inc;

    assign rot       = {i_state.checksum[0], i_state.checksum[7:1]};
    assign folded    = rot + i_rx_byte;
    assign count_inc = i_state.body_count + 8'd1;

    always_comb begin
        o_state  = i_state;
        o_result = '{event_res: pfr_pkg::EV_NONE, byte_value: 8'd0, byte_index: 7'd0,
                     frame_length: 8'd0, running_checksum: 8'd0};
        case (i_state.phase)
            pfr_pkg::PH_LEN: begin
                o_state.body_length = i_rx_byte;
                if (i_rx_byte > MaxLen) begin
                    o_result.event_res = pfr_pkg::EV_BAD;
                    o_state.phase      = pfr_pkg::PH_IDLE;
                    o_state.body_count = 8'd0;
                    o_state.checksum   = 8'd0;
                end else if (i_rx_byte == 8'd0) begin
                    o_state.phase = pfr_pkg::PH_TAIL;
                end else begin
                    o_state.body_count = 8'd0;
                    o_state.checksum   = 8'd0;
                    o_state.phase      = pfr_pkg::PH_BODY;
                end
                o_result.running_checksum = o_state.checksum;
            end
            pfr_pkg::PH_BODY: begin
                o_state.checksum          = folded;
                o_state.body_count        = count_inc;
                o_result.event_res        = pfr_pkg::EV_BYTE;
                o_result.byte_value       = i_rx_byte;
                o_result.byte_index       = i_state.body_count[6:0];
                o_result.running_checksum = folded;
                if (count_inc >= i_state.body_length) begin
                    o_state.phase = pfr_pkg::PH_TAIL;
                end
            end
            pfr_pkg::PH_TAIL: begin
                o_result.running_checksum = i_state.checksum;
                if (i_rx_byte == pfr_pkg::TAIL_BYTE) begin
                    o_state.phase = pfr_pkg::PH_CHECK;
                end else begin
                    o_result.event_res = pfr_pkg::EV_BAD;
                    o_state.phase      = pfr_pkg::PH_IDLE;
                    o_state.body_count = 8'd0;
                    o_state.checksum   = 8'd0;
                end
            end
            pfr_pkg::PH_CHECK: begin
                o_result.running_checksum = i_state.checksum;
                o_result.event_res = (i_rx_byte == i_state.checksum) ?
                                     pfr_pkg::EV_GOOD : pfr_pkg::EV_BAD;
                o_state.phase      = pfr_pkg::PH_IDLE;
                o_state.body_count = 8'd0;
                o_state.checksum   = 8'd0;
            end
            default: begin
                // idle: hunt for the head byte
                o_state.body_count = 8'd0;
                o_state.checksum   = 8'd0;
                o_state.phase = (i_rx_byte == pfr_pkg::HEAD_BYTE) ?
                                pfr_pkg::PH_LEN : pfr_pkg::PH_IDLE;
            end
        endcase
        o_result.frame_length = o_state.body_length;
    end

endmodule

// ===== src/packet_frame_receiver_core.sv =====
// packet_frame_receiver_core: byte-serial deframer with 8-bit rotate-and-add checksum
// result path: an accepted byte passes through the input register and then the result register;
// the result register is filled only while it is empty or being drained
// throughput: one byte per cycle while the result channel is not stalled; one result transaction per input transaction
// reset (i_rst_n low, synchronous): phase idle, length/count/checksum zero, both stages empty
// depends on pfr_pkg and pfr_step
module packet_frame_receiver_core #(
    parameter int MAX_LEN = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_event_res,
    output logic [7:0] o_byte_value,
    output logic [6:0] o_byte_index,
    output logic [7:0] o_frame_length,
    output logic [7:0] o_running_checksum
);

    // input register: holds one accepted byte until the step logic consumes it
    logic             r_in_vld;
    logic [7:0]       r_in_byte;

    // frame state, updated once per consumed byte
    pfr_pkg::t_state  r_state;
    pfr_pkg::t_state  n_state;

    // result register
    logic             r_out_vld;
    pfr_pkg::t_result r_out;
    pfr_pkg::t_result n_out;

    logic             advance;
    logic             in_take;

    // the held byte moves into the result register whenever that register is
    // empty or being drained in the same cycle
    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;
    assign in_take = i_valid && o_ready;

    pfr_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .i_state   (r_state),
        .i_rx_byte (r_in_byte),
        .o_state   (n_state),
        .o_result  (n_out)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // frame state commits together with the result it produced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: pfr_pkg::PH_IDLE, body_length: 8'd0,
                         body_count: 8'd0, checksum: 8'd0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_event_res        = r_out.event_res;
    assign o_byte_value       = r_out.byte_value;
    assign o_byte_index       = r_out.byte_index;
    assign o_frame_length     = r_out.frame_length;
    assign o_running_checksum = r_out.running_checksum;

    // idle always leaves the body counter and checksum cleared
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == pfr_pkg::PH_IDLE |->
            r_state.body_count == 8'd0 && r_state.checksum == 8'd0)
        else $error("idle with stale count or checksum");

    // a delivered body byte always lies inside the announced length
    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.event_res == pfr_pkg::EV_BYTE |->
            {1'b0, r_out.byte_index} < r_out.frame_length)
        else $error("body byte index beyond frame length");

    // a good frame never carries an oversize length
    a_good_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.event_res == pfr_pkg::EV_GOOD |->
            r_out.frame_length <= 8'(MAX_LEN))
        else $error("good frame with oversize length");

    // a held byte is not dropped while the result side stalls
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in_byte))
        else $error("held input byte lost");

    // the body phase is only entered from the length phase
    a_body_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state.phase == pfr_pkg::PH_BODY) |->
            $past(r_state.phase) == pfr_pkg::PH_LEN)
        else $error("body phase entered out of order");

endmodule
